// File: hdl/scfc_pkg.sv
// Shared types and constants for the sensor frame CRC checker.
`timescale 1ns / 1ps
`default_nettype none

package scfc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IdxW   = 3;

  typedef logic [IdxW-1:0]  byte_idx_t;
  typedef logic [CrcW-1:0]  crc_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;

  // CRC seed and reset polynomial (reflected CRC-16).
  localparam crc_t CrcSeed      = 16'hFFFF;
  localparam crc_t CrcPolyReset = 16'hA001;

  // Positions of the bytes within one response frame.
  localparam byte_idx_t IdxFuncCode = 3'd0;
  localparam byte_idx_t IdxRegCount = 3'd1;
  localparam byte_idx_t IdxHumHi    = 3'd2;
  localparam byte_idx_t IdxHumLo    = 3'd3;
  localparam byte_idx_t IdxTempHi   = 3'd4;
  localparam byte_idx_t IdxTempLo   = 3'd5;
  localparam byte_idx_t IdxCrcLo    = 3'd6;
  localparam byte_idx_t IdxCrcHi    = 3'd7;

  // Result status codes.
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

endpackage

`default_nettype wire

// File: hdl/scfc_crc_byte.sv
// One byte of the reflected CRC-16, all eight bit steps unrolled.
`timescale 1ns / 1ps
`default_nettype none

module scfc_crc_byte (
  input  scfc_pkg::crc_t  crc_i,
  input  scfc_pkg::byte_t data_i,
  input  scfc_pkg::crc_t  poly_i,
  output scfc_pkg::crc_t  crc_o
);
  import scfc_pkg::*;

  crc_t acc;

  // Fold the byte into the low bits, then shift right eight times,
  // xoring in the polynomial whenever a one bit drops out.
  always_comb begin
    acc = crc_i ^ {{(CrcW-ByteW){1'b0}}, data_i};
    for (int k = 0; k < ByteW; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ poly_i;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

`default_nettype wire

// File: hdl/sensor_frame_crc_checker_core.sv
// Top level of the sensor response frame CRC checker.
//
// The input channel carries one response byte per beat (rx_byte_i) with
// frame_start_i marking the first byte of a new frame. Frame order is
// function code, register count, humidity high/low, temperature high/low,
// CRC low, CRC high. The output channel gives one beat per complete frame,
// on its eighth byte: status_o (0 match, 1 mismatch) and the raw humidity
// and temperature words in tenths, both zero on a mismatch.
// A byte is accepted every cycle unless the input stalls; a beat goes into an
// input register, the CRC byte update, field capture and compare then run on
// the registered beat, and the result is held in a result register.
// While the receiver stalls a pending result, bytes that finish no frame
// keep flowing; only a byte that would finish a frame waits, and the input
// then stalls. The polynomial register is written with crc_polynomial_we_i
// and resets to 0xA001. Reset clears the frame position and seeds the CRC.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_crc_checker_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  // Configuration
  input  wire               crc_polynomial_we_i,
  input  scfc_pkg::crc_t    crc_polynomial_i,
  // Input channel
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  scfc_pkg::byte_t   rx_byte_i,
  input  wire               frame_start_i,
  // Output channel
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              status_o,
  output scfc_pkg::word_t   humidity_tenths_o,
  output scfc_pkg::word_t   temperature_tenths_o
);
  import scfc_pkg::*;

  crc_t      poly_q;
  logic      s1_valid_q, s1_valid_d;
  byte_t     s1_byte_q;
  logic      s1_start_q;
  byte_idx_t byte_index_q, byte_index_d;
  crc_t      crc_accum_q, crc_accum_d;
  word_t     hum_q, hum_d;
  word_t     temp_q, temp_d;
  byte_t     crc_lo_q, crc_lo_d;
  logic      out_valid_q, out_valid_d;
  logic      status_q;
  word_t     out_hum_q, out_temp_q;

  byte_idx_t idx;
  crc_t      crc_base;
  crc_t      crc_next;
  logic      is_last;
  logic      advance;
  logic      in_acc;
  logic      crc_ok;

  // Polynomial register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CrcPolyReset;
    end else if (crc_polynomial_we_i) begin
      poly_q <= crc_polynomial_i;
    end
  end

  // Handshake: the work stage only waits when it finishes a frame while
  // the previous result is still held by the receiver.
  assign idx      = s1_start_q ? IdxFuncCode : byte_index_q;
  assign is_last  = (idx == IdxCrcHi);
  assign advance  = s1_valid_q && (!is_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= frame_start_i;
    end
  end

  // CRC byte update, seeded at the first byte of a frame.
  assign crc_base = (idx == IdxFuncCode) ? CrcSeed : crc_accum_q;

  scfc_crc_byte u_crc_byte (
    .crc_i  (crc_base),
    .data_i (s1_byte_q),
    .poly_i (poly_q),
    .crc_o  (crc_next)
  );

  assign crc_ok = ({s1_byte_q, crc_lo_q} == crc_accum_q);

  // Frame state update for the byte in the work stage.
  always_comb begin
    byte_index_d = byte_index_q;
    crc_accum_d  = crc_accum_q;
    hum_d        = hum_q;
    temp_d       = temp_q;
    crc_lo_d     = crc_lo_q;
    if (advance) begin
      byte_index_d = idx + 3'd1;
      case (idx)
        IdxCrcLo: crc_lo_d    = s1_byte_q;
        IdxCrcHi: crc_accum_d = CrcSeed;
        default:  crc_accum_d = crc_next;
      endcase
      case (idx)
        IdxHumHi:  hum_d  = {s1_byte_q, hum_q[ByteW-1:0]};
        IdxHumLo:  hum_d  = {hum_q[WordW-1:ByteW], s1_byte_q};
        IdxTempHi: temp_d = {s1_byte_q, temp_q[ByteW-1:0]};
        IdxTempLo: temp_d = {temp_q[WordW-1:ByteW], s1_byte_q};
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= IdxFuncCode;
      crc_accum_q  <= CrcSeed;
      hum_q        <= '0;
      temp_q       <= '0;
      crc_lo_q     <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      crc_accum_q  <= crc_accum_d;
      hum_q        <= hum_d;
      temp_q       <= temp_d;
      crc_lo_q     <= crc_lo_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && is_last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_last) begin
      status_q   <= crc_ok ? StatusOk : StatusCrcErr;
      out_hum_q  <= crc_ok ? hum_q : '0;
      out_temp_q <= crc_ok ? temp_q : '0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign humidity_tenths_o    = out_hum_q;
  assign temperature_tenths_o = out_temp_q;

endmodule

`default_nettype wire

// File: hdl/scfc_checker.sv
// Port-level checks for the sensor frame CRC checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scfc_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_stall_o,
  input wire              out_valid_o,
  input wire              out_stall_i,
  input wire              status_o,
  input scfc_pkg::word_t  humidity_tenths_o,
  input scfc_pkg::word_t  temperature_tenths_o
);
  import scfc_pkg::*;

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(humidity_tenths_o) && $stable(temperature_tenths_o))
    else $error("result payload changed while stalled");

  // A CRC error reports zero readings.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusCrcErr) |->
      (humidity_tenths_o == '0) && (temperature_tenths_o == '0))
    else $error("readings not cleared on CRC error");

  // A new result follows an accepted input beat.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding input beat");

  // The input only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind sensor_frame_crc_checker_core scfc_checker u_scfc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .status_o             (status_o),
  .humidity_tenths_o    (humidity_tenths_o),
  .temperature_tenths_o (temperature_tenths_o)
);

`default_nettype wire

// File: tb/sv/scfc_frame_checker.sv
// Frame scoreboard for the sensor frame CRC checker, with the CRC helper it shares.
`timescale 1ns / 1ps

package scfc_tb_pkg;

  import scfc_pkg::*;

  // One reflected CRC-16 byte step: fold the byte in, then shift out eight bits.
  function automatic crc_t crc16_refl_byte(crc_t crc, byte_t b, crc_t poly);
    crc_t c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module scfc_frame_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  scfc_pkg::crc_t      cfg_poly_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  scfc_pkg::byte_t     rx_byte_i,
  input  logic                frame_start_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                status_i,
  input  scfc_pkg::word_t     humidity_i,
  input  scfc_pkg::word_t     temperature_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  import scfc_pkg::*;
  import scfc_tb_pkg::*;

  typedef struct packed {
    logic  status;
    word_t humidity;
    word_t temperature;
  } frame_result_t;

  // Private copy of the frame state and the polynomial register.
  crc_t          poly_q;
  byte_idx_t     next_pos;
  crc_t          crc_run;
  word_t         hum_word;
  word_t         temp_word;
  byte_t         crc_lo_seen;
  frame_result_t expected_frames[$];

  // Predict on every accepted input beat and compare every accepted output beat.
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    byte_idx_t     idx;
    crc_t          rx_crc;
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      poly_q       = CrcPolyReset;
      next_pos     = IdxFuncCode;
      crc_run      = CrcSeed;
      hum_word     = '0;
      temp_word    = '0;
      crc_lo_seen  = '0;
      expected_frames.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        poly_q = cfg_poly_i;
      end

      if (in_valid_i && !in_stall_i) begin
        idx = frame_start_i ? IdxFuncCode : next_pos;
        if (idx == IdxFuncCode) begin
          crc_run = CrcSeed;
        end
        if (idx <= IdxTempLo) begin
          crc_run = crc16_refl_byte(crc_run, rx_byte_i, poly_q);
        end
        case (idx)
          IdxHumHi:  hum_word[15:8]  = rx_byte_i;
          IdxHumLo:  hum_word[7:0]   = rx_byte_i;
          IdxTempHi: temp_word[15:8] = rx_byte_i;
          IdxTempLo: temp_word[7:0]  = rx_byte_i;
          IdxCrcLo:  crc_lo_seen     = rx_byte_i;
          IdxCrcHi: begin
            // The last byte closes the frame; a bad CRC zeroes both words.
            rx_crc = {rx_byte_i, crc_lo_seen};
            if (rx_crc == crc_run) begin
              want = '{status: StatusOk, humidity: hum_word, temperature: temp_word};
            end else begin
              want = '{status: StatusCrcErr, humidity: '0, temperature: '0};
            end
            expected_frames.push_back(want);
            crc_run = CrcSeed;
          end
          default: ;
        endcase
        next_pos = idx + 3'd1;
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{status: status_i, humidity: humidity_i, temperature: temperature_i};
        if (expected_frames.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("scfc_check: result with none expected: status %0d hum %h temp %h",
                     got.status, got.humidity, got.temperature);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("scfc_check: status/hum/temp expected %0d/%h/%h got %0d/%h/%h",
                       want.status, want.humidity, want.temperature,
                       got.status, got.humidity, got.temperature);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      pending_o <= expected_frames.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Stimulus, clock, reset and verdict for the sensor frame CRC checker testbench.
`timescale 1ns / 1ps

module tb_top;

  import scfc_pkg::*;
  import scfc_tb_pkg::*;

  localparam int unsigned RandomItems  = 1900;
  localparam int unsigned QuietItems   = 200;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 200000;

  localparam crc_t PolyPlan [NumPhases] = '{
    16'h0000, 16'hFFFF, 16'h8408, 16'h0000, 16'hA001, 16'h0001, 16'h8000, 16'h0000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  crc_t        cfg_poly = CrcPolyReset;
  logic        in_valid = 1'b0;
  logic        in_stall;
  byte_t       rx_byte = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  word_t       humidity;
  word_t       temperature;
  int unsigned fail_count;
  int unsigned pending;

  // Stimulus knobs; all but cur_poly and bytes_sent change with nonblocking writes at a clock edge.
  crc_t        cur_poly = CrcPolyReset;
  logic        quiet = 1'b0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  sensor_frame_crc_checker_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .crc_polynomial_we_i  (cfg_we),
    .crc_polynomial_i     (cfg_poly),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .rx_byte_i            (rx_byte),
    .frame_start_i        (frame_start),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .status_o             (status),
    .humidity_tenths_o    (humidity),
    .temperature_tenths_o (temperature)
  );

  scfc_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_poly_i    (cfg_poly),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .humidity_i    (humidity),
    .temperature_i (temperature),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts between open runs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end
  end

  // Present one byte, with an optional idle burst ahead of it, and wait for its beat.
  task automatic put_byte(input byte_t b, input logic s);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    bytes_sent = bytes_sent + 1;
    if (bytes_sent >= RandomItems - QuietItems + 25) begin
      quiet <= 1'b1;
    end
  endtask

  // Send a full frame; a bad frame gets one bit flipped after the CRC is appended.
  task automatic put_frame(input bit good, input logic with_start,
                           input word_t hum, input word_t temp);
    byte_t fr [8];
    crc_t  c;
    fr[0] = byte_t'($urandom);
    fr[1] = byte_t'($urandom);
    fr[2] = hum[15:8];
    fr[3] = hum[7:0];
    fr[4] = temp[15:8];
    fr[5] = temp[7:0];
    c = CrcSeed;
    for (int i = 0; i < 6; i++) begin
      c = crc16_refl_byte(c, fr[i], cur_poly);
    end
    fr[6] = c[7:0];
    fr[7] = c[15:8];
    if (!good) begin
      fr[$urandom_range(0, 7)] ^= byte_t'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < 8; i++) begin
      put_byte(fr[i], (i == 0) ? with_start : 1'b0);
    end
  endtask

  // Field values lean toward the extremes now and then.
  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return word_t'($urandom);
  endfunction

  // Mostly well-formed frames, plus cut-off frames and loose bytes.
  task automatic random_burst();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 74) begin
      put_frame($urandom_range(0, 99) < 65, $urandom_range(0, 99) < 85,
                pick_word(), pick_word());
    end else begin
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
        put_byte(byte_t'($urandom),
                 (kind < 88 && i == 0) ? 1'b1 : ($urandom_range(0, 3) == 0));
      end
    end
  endtask

  // Drain every expected result, then let the pipeline settle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_poly(input crc_t v);
    cfg_we   <= 1'b1;
    cfg_poly <= v;
    cur_poly = v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int unsigned phase_end;
    crc_t        next_poly;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset polynomial.
    put_frame(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    // No frame start: the position wraps on its own; bad CRC zeroes the words.
    put_frame(1'b0, 1'b0, 16'h0000, 16'h0000);
    // A frame start in the middle drops the partial frame.
    put_byte(8'h03, 1'b1);
    put_byte(8'h04, 1'b0);
    put_byte(8'h81, 1'b0);
    put_frame(1'b1, 1'b1, 16'h01F4, 16'h8123);

    // Random phases, each at its own polynomial and idling mix.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == 3 || p == 7) begin
        next_poly = crc_t'($urandom);
      end else begin
        next_poly = PolyPlan[p];
      end
      write_poly(next_poly);
      gap_pct   <= (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 12 : 35);
      stall_pct <= (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 20 : 45);
      phase_end = 25 + (p + 1) * (RandomItems / NumPhases);
      while (bytes_sent < phase_end) begin
        random_burst();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
